// File: design/stable_priority_queue_defines.svh
// Assertion macros for the stable priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a condition at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition in one cycle implies another in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT_ALWAYS(lbl, expr, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/spq_pkg.sv
// Package with types and constants of the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;
    localparam int PRIO_W           = 32;
    localparam int DATA_W           = 32;
    localparam int STATUS_W         = 2;
    localparam int OCC_W            = 5;
    localparam int DEFAULT_CAPACITY = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } spq_status_t;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } spq_kind_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ENQ,
        OP_DEQ
    } spq_op_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        spq_op_t                  op;
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] value;
    } spq_cmd_t;

    // Contents of one cell.
    typedef struct packed {
        logic                     valid;
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] value;
    } spq_entry_t;
endpackage
`default_nettype wire

// File: design/spq_req_if.sv
// Request channel interface: operation kind, priority and payload.
`timescale 1ns / 1ps
`default_nettype none
interface spq_req_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic signed [spq_pkg::PRIO_W-1:0] priority_req;
    logic signed [spq_pkg::DATA_W-1:0] payload;

    modport source (output valid, output kind, output priority_req, output payload,
                    input ready);
    modport sink   (input valid, input kind, input priority_req, input payload,
                    output ready);
endinterface
`default_nettype wire

// File: design/spq_rsp_if.sv
// Response channel interface: removed value, status and occupancy.
`timescale 1ns / 1ps
`default_nettype none
interface spq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [spq_pkg::DATA_W-1:0]   out_value;
    logic        [spq_pkg::STATUS_W-1:0] status;
    logic        [spq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output out_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input out_value, input status, input occupancy,
                    output ready);
endinterface
`default_nettype wire

// File: design/spq_cell.sv
// One slot of the sorted chain: compare, hold, take new entry or shift.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire spq_pkg::spq_cmd_t    cmd,
    input  wire spq_pkg::spq_entry_t  prev_entry,
    input  wire logic                 prev_keep,
    input  wire spq_pkg::spq_entry_t  next_entry,
    output spq_pkg::spq_entry_t       entry,
    output logic                      keep
);
    logic                               valid_reg;
    logic signed [spq_pkg::PRIO_W-1:0]  prio_reg;
    logic signed [spq_pkg::DATA_W-1:0]  value_reg;
    spq_pkg::spq_entry_t                entry_next;

    assign entry = '{valid: valid_reg, prio: prio_reg, value: value_reg};

    // Stay in place when ahead of the new entry (greater or equal priority).
    assign keep = valid_reg && ($signed(prio_reg) >= $signed(cmd.prio));

    always_comb
    begin
        entry_next = entry;
        case (cmd.op)
            spq_pkg::OP_ENQ:
            begin
                if (keep)
                begin
                    entry_next = entry;
                end
                else if (prev_keep)
                begin
                    entry_next = '{valid: 1'b1, prio: cmd.prio, value: cmd.value};
                end
                else
                begin
                    entry_next = prev_entry;
                end
            end
            spq_pkg::OP_DEQ:
            begin
                entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg  <= entry_next.prio;
        value_reg <= entry_next.value;
    end
endmodule
`default_nettype wire

// File: design/spq_chain.sv
// Row of cells holding the queue in service order, head at slot 0.
`timescale 1ns / 1ps
`default_nettype none
module spq_chain #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire spq_pkg::spq_cmd_t    cmd,
    output spq_pkg::spq_entry_t       head,
    output spq_pkg::spq_entry_t       tail
);
    spq_pkg::spq_entry_t ent  [CAPACITY];
    logic                kp   [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            spq_pkg::spq_entry_t prev_e;
            spq_pkg::spq_entry_t next_e;
            logic                prev_k;

            if (i == 0)
            begin : g_first
                assign prev_e = '0;
                assign prev_k = 1'b1;
            end
            else
            begin : g_mid
                assign prev_e = ent[i-1];
                assign prev_k = kp[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign next_e = '0;
            end
            else
            begin : g_inner
                assign next_e = ent[i+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_entry (prev_e),
                .prev_keep  (prev_k),
                .next_entry (next_e),
                .entry      (ent[i]),
                .keep       (kp[i])
            );
        end
    endgenerate

    assign head = ent[0];
    assign tail = ent[CAPACITY-1];
endmodule
`default_nettype wire

// File: design/stable_priority_queue.sv
// A request transfer shows its response in the output register in the next cycle.
// Throughput: one request per cycle while the response side drains; every cell compares and shifts in parallel.
// The request side stalls only while an unread response sits in the output register.
// Reset: asynchronous, active low; empties the queue (cell valid bits and count cleared)
// and drops any pending response. Entry contents need no reset.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_priority_queue_defines.svh"
module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Occupancy counter, mirrors the number of valid cells.
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;

    // Response register.
    logic                               rsp_valid_reg;
    logic signed [spq_pkg::DATA_W-1:0]  rsp_value_reg;
    logic signed [spq_pkg::DATA_W-1:0]  rsp_value_next;
    spq_pkg::spq_status_t               rsp_status_reg;
    spq_pkg::spq_status_t               rsp_status_next;
    logic [spq_pkg::OCC_W-1:0]          rsp_occ_reg;

    spq_pkg::spq_cmd_t                  cmd;
    spq_pkg::spq_entry_t                head;
    spq_pkg::spq_entry_t                tail;
    logic                               accept;
    logic                               is_full;
    logic                               is_empty;

    // Take a new request whenever the response slot is free or being drained.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Decode the request into a chain command; drop enqueue when full and
    // dequeue when empty, leaving the chain untouched.
    always_comb
    begin
        cmd.op          = spq_pkg::OP_HOLD;
        cmd.prio        = req.priority_req;
        cmd.value       = req.payload;
        count_next      = count_reg;
        rsp_value_next  = '0;
        rsp_status_next = spq_pkg::ST_OK;
        if (accept)
        begin
            case (spq_pkg::spq_kind_t'(req.kind))
                spq_pkg::KIND_ENQ:
                begin
                    if (is_full)
                    begin
                        rsp_status_next = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.op     = spq_pkg::OP_ENQ;
                        count_next = count_reg + 1'b1;
                    end
                end
                spq_pkg::KIND_DEQ:
                begin
                    if (is_empty)
                    begin
                        rsp_status_next = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.op         = spq_pkg::OP_DEQ;
                        count_next     = count_reg - 1'b1;
                        rsp_value_next = head.value;
                    end
                end
                default:
                begin
                    cmd.op = spq_pkg::OP_HOLD;
                end
            endcase
        end
    end

    spq_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head),
        .tail  (tail)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Load the response payload on each request transfer; occupancy shows
    // the low bits of the count after this request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_value_reg  <= rsp_value_next;
            rsp_status_reg <= rsp_status_next;
            rsp_occ_reg    <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_value = rsp_value_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.occupancy = rsp_occ_reg;

    // Counter and chain must agree on empty and full.
    `SPQ_ASSERT_ALWAYS(a_empty_match, is_empty == !head.valid, "count and head valid disagree")
    `SPQ_ASSERT_ALWAYS(a_full_match, is_full == tail.valid, "count and tail valid disagree")
    // An enqueue into a non-full queue grows the count by one.
    `SPQ_ASSERT_NEXT(a_enq_grow, cmd.op == spq_pkg::OP_ENQ, count_reg == $past(count_reg) + 1'b1, "enqueue did not grow count")
    // A dequeue from a non-empty queue shrinks the count by one.
    `SPQ_ASSERT_NEXT(a_deq_shrink, cmd.op == spq_pkg::OP_DEQ, count_reg == $past(count_reg) - 1'b1, "dequeue did not shrink count")
    // A response stalled by the sink blocks new requests.
    `SPQ_ASSERT_ALWAYS(a_stall_blocks, !(rsp_valid_reg && !rsp.ready) || !accept, "request taken over a stalled response")
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the stable priority queue: random traffic with a queue predictor.
`timescale 1ns / 1ps
module tb_top;
    import spq_pkg::*;

    localparam int DEPTH      = DEFAULT_CAPACITY;
    localparam int CYCLE_CAP  = 200000;
    localparam int RAND_ITEMS = 400;

    // Pacing of both sides, carried by each queued item so that it follows the stimulus.
    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH
    } spq_pace_t;

    typedef struct {
        spq_kind_t                kind;
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] payload;
        spq_pace_t                pace;
        bit                       drain;
    } spq_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        spq_status_t              status;
        logic [OCC_W-1:0]         occupancy;
    } spq_result_t;

    typedef struct {
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] value;
    } held_entry_t;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_priority_queue #(
        .CAPACITY(DEPTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    spq_item_t   req_backlog[$];   // items waiting to be driven
    spq_result_t awaited[$];       // predicted responses, oldest first
    held_entry_t held[$];          // predictor copy of the queue, head at index 0
    spq_item_t   on_wire;          // item currently presented on the request channel
    spq_pace_t   cur_pace;
    int          mismatches;
    int          cycle_count;

    // Apply one request to the predictor and return the response it must produce.
    function automatic spq_result_t serve_item(spq_item_t it);
        spq_result_t r;
        held_entry_t e;
        int          pos;
        r.value  = '0;
        r.status = ST_OK;
        if (it.kind == KIND_ENQ)
        begin
            if (held.size() >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // Go behind every entry of greater or equal priority: FIFO among equals.
                pos = 0;
                while (pos < held.size() && held[pos].prio >= it.prio)
                begin
                    pos++;
                end
                e.prio  = it.prio;
                e.value = it.payload;
                held.insert(pos, e);
            end
        end
        else if (held.size() == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            e       = held.pop_front();
            r.value = e.value;
        end
        r.occupancy = OCC_W'(held.size());
        return r;
    endfunction

    task automatic add_item(spq_kind_t kind, logic [31:0] prio, logic [31:0] payload,
                            spq_pace_t pace, bit drain);
        spq_item_t it;
        it.kind    = kind;
        it.prio    = prio;
        it.payload = payload;
        it.pace    = pace;
        it.drain   = drain;
        req_backlog.push_back(it);
    endtask

    // Free-running clock, 10 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run watchdog: a stuck handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** stable_priority_queue: FAILED **");
            $finish;
        end
    end

    // Request driver: predict each transfer, then present the next item unless idling.
    always @(posedge clk or negedge rst_n)
    begin : drive_req
        logic present;
        int   idle_pct;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            present = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                awaited.push_back(serve_item(on_wire));
                present = 1'b0;
            end
            if (!present && req_backlog.size() != 0)
            begin
                case (req_backlog[0].pace)
                    PACE_SRC_IDLE: idle_pct = 57;
                    PACE_BOTH:     idle_pct = 6;
                    default:       idle_pct = 0;
                endcase
                // Hold off a drain-marked item until every response is back.
                if (!(req_backlog[0].drain && awaited.size() != 0) &&
                    $urandom_range(99) >= idle_pct)
                begin
                    on_wire = req_backlog.pop_front();
                    req_ch.kind         <= on_wire.kind;
                    req_ch.priority_req <= on_wire.prio;
                    req_ch.payload      <= on_wire.payload;
                    cur_pace            <= on_wire.pace;
                    present = 1'b1;
                end
            end
            req_ch.valid <= present;
        end
    end

    // Response monitor: compare each transfer with the oldest prediction, stall at random.
    always @(posedge clk or negedge rst_n)
    begin : watch_rsp
        spq_result_t want;
        int          stall_pct;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: response with none expected: value %0d status %0d occ %0d",
                             $time, rsp_ch.out_value, rsp_ch.status, rsp_ch.occupancy);
                    mismatches++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (rsp_ch.out_value !== want.value)
                    begin
                        $display("%0t: out_value expected %0d actual %0d",
                                 $time, want.value, rsp_ch.out_value);
                        mismatches++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.occupancy !== want.occupancy)
                    begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occupancy, rsp_ch.occupancy);
                        mismatches++;
                    end
                end
            end
            case (cur_pace)
                PACE_SNK_STALL: stall_pct = 57;
                PACE_BOTH:      stall_pct = 6;
                default:        stall_pct = 0;
            endcase
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stimulus: directed corner cases, then bursts that swing the queue between empty and full.
    initial
    begin
        spq_kind_t   k;
        logic [31:0] p;
        int          blk;
        int          made;
        int          burst;
        int          bias;
        int          i;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_ENQ;
        req_ch.priority_req = '0;
        req_ch.payload      = '0;
        rsp_ch.ready        = 1'b0;
        cur_pace            = PACE_FREE;
        mismatches          = 0;
        cycle_count         = 0;

        // Dequeue on an empty queue first.
        add_item(KIND_DEQ, 32'h0, 32'h0, PACE_FREE, 1'b0);
        // Priority and payload extremes.
        add_item(KIND_ENQ, 32'h7fffffff, 32'h80000000, PACE_FREE, 1'b0);
        add_item(KIND_ENQ, 32'h80000000, 32'h7fffffff, PACE_FREE, 1'b0);
        // Equal priorities keep arrival order, also at the head.
        add_item(KIND_ENQ, 32'h0, 32'h1, PACE_FREE, 1'b0);
        add_item(KIND_ENQ, 32'h0, 32'h2, PACE_FREE, 1'b0);
        add_item(KIND_ENQ, 32'hffffffff, 32'hffffffff, PACE_FREE, 1'b0);
        add_item(KIND_ENQ, 32'h0, 32'h3, PACE_FREE, 1'b0);
        add_item(KIND_ENQ, 32'h7fffffff, 32'h5, PACE_FREE, 1'b0);
        // Drain all of it and go one past empty.
        for (i = 0; i < 8; i++)
        begin
            add_item(KIND_DEQ, $urandom, $urandom, PACE_FREE, 1'b0);
        end

        // Eight blocks cycle through the four pacing phases; each block starts
        // with a pause until the queue has answered everything.
        for (blk = 0; blk < RAND_ITEMS / 50; blk++)
        begin
            made = 0;
            while (made < 50)
            begin
                burst = $urandom_range(24, 8);
                case ($urandom_range(2))
                    0:       bias = 85;
                    1:       bias = 15;
                    default: bias = 50;
                endcase
                for (i = 0; i < burst && made < 50; i++)
                begin
                    if ($urandom_range(99) < bias)
                        k = KIND_ENQ;
                    else
                        k = KIND_DEQ;
                    // Mix tie-prone small priorities, extremes and full-range values.
                    case ($urandom_range(3))
                        0:       p = $urandom_range(4) - 2;
                        1:       p = ($urandom_range(1) != 0) ? 32'h7fffffff : 32'h80000000;
                        default: p = $urandom;
                    endcase
                    add_item(k, p, $urandom, spq_pace_t'(blk % 4), made == 0);
                    made++;
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the backlog to go out and every response to come back; sample
        // at the falling edge so that the driver and monitor updates have settled.
        while (req_backlog.size() != 0 || req_ch.valid || awaited.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("** stable_priority_queue: PASSED **");
        end
        else
        begin
            $display("** stable_priority_queue: FAILED **");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+design
design/spq_pkg.sv
design/spq_req_if.sv
design/spq_rsp_if.sv
design/spq_cell.sv
design/spq_chain.sv
design/stable_priority_queue.sv
tb/sv/tb_top.sv
